>>> rtl/pwg_pkg.sv
package pwg_pkg;

  // Register map, index into the configuration space
  localparam int unsigned REG_LOW    = 0;
  localparam int unsigned REG_HIGH   = 1;
  localparam int unsigned REG_DELAY  = 2;
  localparam int unsigned REG_RISE   = 3;
  localparam int unsigned REG_FALL   = 4;
  localparam int unsigned REG_WIDTH  = 5;
  localparam int unsigned REG_PERIOD = 6;
  localparam int unsigned NUM_REGS   = 7;

  // Which segment of the pulse a sample falls in
  typedef enum logic [1:0] {
    SEG_LO   = 2'd0,
    SEG_HI   = 2'd1,
    SEG_RAMP = 2'd2,
    SEG_OPEN = 2'd3
  } seg_t;

endpackage

>>> rtl/pwg_in_if.sv
interface pwg_in_if #(
  parameter int TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] time_ticks;

  modport source (output valid, output time_ticks, input ready);
  modport sink   (input valid, input time_ticks, output ready);
endinterface

>>> rtl/pwg_out_if.sv
interface pwg_out_if #(
  parameter int LEVEL_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [LEVEL_WIDTH-1:0] voltage;

  modport source (output valid, output voltage, input ready);
  modport sink   (input valid, input voltage, output ready);
endinterface

>>> rtl/pulse_waveform_generator_unit.sv
// Trapezoidal pulse source. Each transfer on in_ch carries a time in ticks; the
// block answers with one transfer on out_ch carrying the pulse voltage at that
// time. Shape registers (levels, delay, rise, fall, width, period) are written
// over the APB port at byte address 4*index (8*index when TIME_WIDTH > 32).
// Write them only while no sample is in flight.
// Throughput: one sample per cycle while the receiver takes results. The period
// reduction is a one-bit-per-stage remainder pipeline (TIME_WIDTH stages), the
// ramp product is built 32 bits of time per stage, and the ramp division is a
// one-bit-per-stage quotient pipeline (LEVEL_WIDTH stages).
// Reset empties the pipeline and clears all shape registers to zero.
// When the receiver stalls, the whole pipeline holds in place and in_ch.ready
// drops until the waiting result is taken; nothing is lost or repeated.
module pulse_waveform_generator_unit #(
  parameter int TIME_WIDTH  = 32,
  parameter int LEVEL_WIDTH = 16,
  localparam int DW = (TIME_WIDTH > 32) ? 64 : 32,
  localparam int SH = (TIME_WIDTH > 32) ? 3 : 2,
  localparam int AW = $clog2(pwg_pkg::NUM_REGS << SH)
) (
  input  logic          clk,
  input  logic          rst_n,
  pwg_in_if.sink        in_ch,
  pwg_out_if.source     out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready
);
  localparam int TW  = TIME_WIDTH;
  localparam int LW  = LEVEL_WIDTH;
  localparam int NCH = (TW + 31) / 32;
  localparam int EW  = NCH * 32;
  localparam int PW  = LW + EW;
  localparam int IW  = AW - SH;

  // ---------------- configuration ----------------
  logic signed [LW-1:0] low_r, high_r;
  logic [TW-1:0] delay_r, rise_r, fall_r, width_r, period_r;
  logic [IW-1:0] reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AW-1:SH];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= '0;
      high_r   <= '0;
      delay_r  <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
      width_r  <= '0;
      period_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        IW'(pwg_pkg::REG_LOW):    low_r    <= pwdata[LW-1:0];
        IW'(pwg_pkg::REG_HIGH):   high_r   <= pwdata[LW-1:0];
        IW'(pwg_pkg::REG_DELAY):  delay_r  <= pwdata[TW-1:0];
        IW'(pwg_pkg::REG_RISE):   rise_r   <= pwdata[TW-1:0];
        IW'(pwg_pkg::REG_FALL):   fall_r   <= pwdata[TW-1:0];
        IW'(pwg_pkg::REG_WIDTH):  width_r  <= pwdata[TW-1:0];
        IW'(pwg_pkg::REG_PERIOD): period_r <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      IW'(pwg_pkg::REG_LOW):    prdata = DW'({low_r});
      IW'(pwg_pkg::REG_HIGH):   prdata = DW'({high_r});
      IW'(pwg_pkg::REG_DELAY):  prdata = DW'(delay_r);
      IW'(pwg_pkg::REG_RISE):   prdata = DW'(rise_r);
      IW'(pwg_pkg::REG_FALL):   prdata = DW'(fall_r);
      IW'(pwg_pkg::REG_WIDTH):  prdata = DW'(width_r);
      IW'(pwg_pkg::REG_PERIOD): prdata = DW'(period_r);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic                 out_valid_r;
  logic signed [LW-1:0] out_voltage_r;
  logic                 en;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.voltage = out_voltage_r;

  // ---------------- period reduction ----------------
  // Restoring remainder, one dividend bit per stage. A zero period leaves the
  // time unchanged since every compare against zero subtracts nothing.
  typedef struct packed {
    logic          v;
    logic [TW-1:0] rem;
    logic [TW-1:0] num;
  } md_t;

  md_t md_r [0:TW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r[0].v <= 1'b0;
    end else if (en) begin
      md_r[0].v <= in_ch.valid;
    end
    if (en) begin
      md_r[0].rem <= '0;
      md_r[0].num <= in_ch.time_ticks;
    end
  end

  for (genvar i = 0; i < TW; i++) begin : g_mod
    logic [TW:0]   sh;
    logic [TW-1:0] rem_nxt;
    always_comb begin
      sh = {md_r[i].rem, md_r[i].num[TW-1]};
      if (sh >= {1'b0, period_r}) rem_nxt = TW'(sh - {1'b0, period_r});
      else rem_nxt = sh[TW-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_r[i+1].v <= 1'b0;
      end else if (en) begin
        md_r[i+1].v <= md_r[i].v;
      end
      if (en) begin
        md_r[i+1].rem <= rem_nxt;
        md_r[i+1].num <= {md_r[i].num[TW-2:0], 1'b0};
      end
    end
  end

  // ---------------- segment classification ----------------
  typedef struct packed {
    logic          v;
    pwg_pkg::seg_t seg;
    logic          rising;
    logic [TW-1:0] t;
  } sg_t;

  sg_t s1_r, s2_r, s3_r, s1_nxt, s2_nxt, s3_nxt;

  always_comb begin
    s1_nxt        = '0;
    s1_nxt.v      = md_r[TW].v;
    s1_nxt.t      = md_r[TW].rem - delay_r;
    s1_nxt.seg    = (md_r[TW].rem <= delay_r) ? pwg_pkg::SEG_LO : pwg_pkg::SEG_OPEN;
  end

  always_comb begin
    s2_nxt = s1_r;
    if (s1_r.seg == pwg_pkg::SEG_OPEN && rise_r != '0) begin
      if (s1_r.t <= rise_r) begin
        s2_nxt.seg    = pwg_pkg::SEG_RAMP;
        s2_nxt.rising = 1'b1;
      end else begin
        s2_nxt.t = s1_r.t - rise_r;
      end
    end
  end

  always_comb begin
    s3_nxt = s2_r;
    if (s2_r.seg == pwg_pkg::SEG_OPEN) begin
      s3_nxt.rising = 1'b0;
      s3_nxt.t      = s2_r.t - width_r;
      if (s2_r.t <= width_r) s3_nxt.seg = pwg_pkg::SEG_HI;
      else if (fall_r != '0 && s3_nxt.t <= fall_r) s3_nxt.seg = pwg_pkg::SEG_RAMP;
      else s3_nxt.seg = pwg_pkg::SEG_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.v <= 1'b0;
      s2_r.v <= 1'b0;
      s3_r.v <= 1'b0;
    end else if (en) begin
      s1_r.v <= s1_nxt.v;
      s2_r.v <= s2_nxt.v;
      s3_r.v <= s3_nxt.v;
    end
    if (en) begin
      {s1_r.seg, s1_r.rising, s1_r.t} <= {s1_nxt.seg, s1_nxt.rising, s1_nxt.t};
      {s2_r.seg, s2_r.rising, s2_r.t} <= {s2_nxt.seg, s2_nxt.rising, s2_nxt.t};
      {s3_r.seg, s3_r.rising, s3_r.t} <= {s3_nxt.seg, s3_nxt.rising, s3_nxt.t};
    end
  end

  // ---------------- ramp product ----------------
  typedef struct packed {
    logic          v;
    pwg_pkg::seg_t seg;
    logic          rising;
    logic          neg;
    logic [LW-1:0] mag;
    logic [EW-1:0] el;
    logic [PW-1:0] acc;
  } mu_t;

  mu_t mu_r [0:NCH];
  mu_t mu0_nxt;
  logic signed [LW:0] diff;

  always_comb begin
    diff = s3_r.rising ? (LW+1)'(high_r) - (LW+1)'(low_r)
                       : (LW+1)'(low_r) - (LW+1)'(high_r);
    mu0_nxt        = '0;
    mu0_nxt.v      = s3_r.v;
    mu0_nxt.seg    = s3_r.seg;
    mu0_nxt.rising = s3_r.rising;
    mu0_nxt.neg    = diff[LW];
    mu0_nxt.mag    = diff[LW] ? LW'(-diff) : diff[LW-1:0];
    mu0_nxt.el     = EW'(s3_r.t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r[0].v <= 1'b0;
    end else if (en) begin
      mu_r[0].v <= mu0_nxt.v;
    end
    if (en) begin
      {mu_r[0].seg, mu_r[0].rising, mu_r[0].neg, mu_r[0].mag, mu_r[0].el, mu_r[0].acc}
        <= {mu0_nxt.seg, mu0_nxt.rising, mu0_nxt.neg, mu0_nxt.mag, mu0_nxt.el,
            mu0_nxt.acc};
    end
  end

  for (genvar k = 0; k < NCH; k++) begin : g_mul
    logic [LW+31:0] pp;
    logic [PW-1:0]  acc_nxt;
    assign pp      = mu_r[k].mag * mu_r[k].el[32*k +: 32];
    assign acc_nxt = mu_r[k].acc + (PW'(pp) << (32 * k));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mu_r[k+1].v <= 1'b0;
      end else if (en) begin
        mu_r[k+1].v <= mu_r[k].v;
      end
      if (en) begin
        mu_r[k+1].seg    <= mu_r[k].seg;
        mu_r[k+1].rising <= mu_r[k].rising;
        mu_r[k+1].neg    <= mu_r[k].neg;
        mu_r[k+1].mag    <= mu_r[k].mag;
        mu_r[k+1].el     <= mu_r[k].el;
        mu_r[k+1].acc    <= acc_nxt;
      end
    end
  end

  // ---------------- ramp division ----------------
  // Quotient never exceeds the level difference, so the upper product bits
  // already sit below the edge length and only LW quotient bits remain.
  typedef struct packed {
    logic          v;
    pwg_pkg::seg_t seg;
    logic          rising;
    logic          neg;
    logic [TW-1:0] rem;
    logic [LW-1:0] num;
    logic [LW-1:0] quo;
  } dv_t;

  dv_t dv_r [0:LW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].v <= 1'b0;
    end else if (en) begin
      dv_r[0].v <= mu_r[NCH].v;
    end
    if (en) begin
      dv_r[0].seg    <= mu_r[NCH].seg;
      dv_r[0].rising <= mu_r[NCH].rising;
      dv_r[0].neg    <= mu_r[NCH].neg;
      dv_r[0].rem    <= mu_r[NCH].acc[LW +: TW];
      dv_r[0].num    <= mu_r[NCH].acc[LW-1:0];
      dv_r[0].quo    <= '0;
    end
  end

  for (genvar j = 0; j < LW; j++) begin : g_div
    logic [TW:0]   sh;
    logic [TW-1:0] len;
    logic          take;
    assign len  = dv_r[j].rising ? rise_r : fall_r;
    assign sh   = {dv_r[j].rem, dv_r[j].num[LW-1]};
    assign take = sh >= {1'b0, len};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1].v <= 1'b0;
      end else if (en) begin
        dv_r[j+1].v <= dv_r[j].v;
      end
      if (en) begin
        dv_r[j+1].seg    <= dv_r[j].seg;
        dv_r[j+1].rising <= dv_r[j].rising;
        dv_r[j+1].neg    <= dv_r[j].neg;
        dv_r[j+1].rem    <= take ? TW'(sh - {1'b0, len}) : sh[TW-1:0];
        dv_r[j+1].num    <= {dv_r[j].num[LW-2:0], 1'b0};
        dv_r[j+1].quo    <= {dv_r[j].quo[LW-2:0], take};
      end
    end
  end

  // ---------------- output ----------------
  logic signed [LW-1:0] from_lvl;
  logic signed [LW:0]   ramp_val;
  logic signed [LW-1:0] volt_nxt;

  always_comb begin
    from_lvl = dv_r[LW].rising ? low_r : high_r;
    if (dv_r[LW].neg) ramp_val = (LW+1)'(from_lvl) - (LW+1)'({1'b0, dv_r[LW].quo});
    else ramp_val = (LW+1)'(from_lvl) + (LW+1)'({1'b0, dv_r[LW].quo});
    case (dv_r[LW].seg)
      pwg_pkg::SEG_HI:   volt_nxt = high_r;
      pwg_pkg::SEG_RAMP: volt_nxt = ramp_val[LW-1:0];
      default:           volt_nxt = low_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[LW].v;
    end
    if (en) begin
      out_voltage_r <= volt_nxt;
    end
  end

endmodule

>>> dv/pulse_waveform_generator_unit_tb.sv
`timescale 1ns / 100ps

module pulse_waveform_generator_unit_tb;

  localparam int TW = 32;
  localparam int LW = 16;
  localparam int AW = $clog2(pwg_pkg::NUM_REGS << 2);
  localparam int LATENCY = TW + LW + 1 + 7;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pwg_in_if #(.TIME_WIDTH(TW)) in_ch ();
  pwg_out_if #(.LEVEL_WIDTH(LW)) out_ch ();

  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  pulse_waveform_generator_unit #(.TIME_WIDTH(TW), .LEVEL_WIDTH(LW)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shape registers mirrored on the checker side
  logic signed [LW-1:0] shape_low, shape_high;
  logic [TW-1:0] shape_delay, shape_rise, shape_fall, shape_width, shape_period;

  logic [TW-1:0]        pending_times[$];
  logic signed [LW-1:0] expected_volts[$];
  int  error_count = 0;
  int  checked_count = 0;
  int  idle_pct = 27;
  bit  out_idle_en = 1'b1;
  int  quiet_cycles = 0;
  bit  drive_busy = 1'b0;

  function automatic logic signed [LW-1:0] edge_value(
      logic signed [LW-1:0] from, logic signed [LW-1:0] to,
      logic [TW-1:0] elapsed, logic [TW-1:0] len);
    logic signed [LW+1:0] diff;
    logic [LW+1:0] mag;
    logic [LW+TW+1:0] prod;
    logic [LW+TW+1:0] q;
    diff = $signed({to[LW-1], to}) - $signed({from[LW-1], from});
    mag = diff < 0 ? -diff : diff;
    prod = mag * elapsed;
    q = prod / len;
    if (diff < 0)
      return LW'($signed({from[LW-1], from}) - $signed(q[LW+1:0]));
    return LW'($signed({from[LW-1], from}) + $signed(q[LW+1:0]));
  endfunction

  function automatic logic signed [LW-1:0] voltage_at(logic [TW-1:0] t_in);
    logic [TW-1:0] t;
    t = t_in;
    if (shape_period != 0) t = t % shape_period;
    if (t <= shape_delay) return shape_low;
    t = t - shape_delay;
    if (shape_rise != 0) begin
      if (t <= shape_rise) return edge_value(shape_low, shape_high, t, shape_rise);
      t = t - shape_rise;
    end
    if (t <= shape_width) return shape_high;
    t = t - shape_width;
    if (shape_fall != 0 && t <= shape_fall)
      return edge_value(shape_high, shape_low, t, shape_fall);
    return shape_low;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AW'(idx << 2); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pwg_pkg::REG_LOW:    shape_low = value[LW-1:0];
      pwg_pkg::REG_HIGH:   shape_high = value[LW-1:0];
      pwg_pkg::REG_DELAY:  shape_delay = value;
      pwg_pkg::REG_RISE:   shape_rise = value;
      pwg_pkg::REG_FALL:   shape_fall = value;
      pwg_pkg::REG_WIDTH:  shape_width = value;
      pwg_pkg::REG_PERIOD: shape_period = value;
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [31:0] lo, hi, dl, rs, fl, wd, pd);
    write_reg(pwg_pkg::REG_LOW, lo);
    write_reg(pwg_pkg::REG_HIGH, hi);
    write_reg(pwg_pkg::REG_DELAY, dl);
    write_reg(pwg_pkg::REG_RISE, rs);
    write_reg(pwg_pkg::REG_FALL, fl);
    write_reg(pwg_pkg::REG_WIDTH, wd);
    write_reg(pwg_pkg::REG_PERIOD, pd);
  endtask

  // hold until every queued sample is sent and answered, then let the pipe drain
  task automatic wait_drained();
    while (pending_times.size() != 0 || drive_busy || expected_volts.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.time_ticks <= '0;
      drive_busy <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_volts.push_back(voltage_at(in_ch.time_ticks));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_times.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.time_ticks <= pending_times.pop_front();
          drive_busy <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
          drive_busy <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_volts.size() == 0) begin
          report_mismatch($sformatf("unexpected voltage %0d", out_ch.voltage));
        end else begin
          logic signed [LW-1:0] exp_v;
          exp_v = expected_volts.pop_front();
          checked_count++;
          if (out_ch.voltage !== exp_v)
            report_mismatch($sformatf("voltage %0d, want %0d", out_ch.voltage, exp_v));
        end
      end
      out_ch.ready <= !out_idle_en || $urandom_range(99) >= idle_pct;
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles <= 0;
    else if (pending_times.size() != 0 || expected_volts.size() != 0 || drive_busy)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_volts.size());
      $display("pulse_waveform_generator_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] rand_time();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(300);
      default: return $urandom_range(2000);
    endcase
  endfunction

  function automatic logic [31:0] rand_level();
    case ($urandom_range(3))
      0: return 32'h0000_8000;
      1: return 32'h0000_7fff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    shape_low = '0; shape_high = '0; shape_delay = '0; shape_rise = '0;
    shape_fall = '0; shape_width = '0; shape_period = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape: all zero
    pending_times.push_back(32'd0);
    pending_times.push_back(32'hffff_ffff);
    wait_drained();

    // one-shot, full-swing levels, boundaries of every segment
    set_shape(32'h8000, 32'h7fff, 10, 7, 5, 3, 0);
    for (int t = 0; t <= 28; t += 2) pending_times.push_back(TW'(t));
    pending_times.push_back(10); pending_times.push_back(17);
    pending_times.push_back(20); pending_times.push_back(25);
    pending_times.push_back(32'hffff_ffff);
    wait_drained();

    // zero edges, periodic, max registers
    set_shape(32'h7fff, 32'h8000, 32'hffff_fffe, 32'hffff_ffff, 0, 32'hffff_ffff,
              32'hffff_ffff);
    pending_times.push_back(32'hffff_fffe); pending_times.push_back(32'hffff_ffff);
    pending_times.push_back(32'hffff_fffd); pending_times.push_back(0);
    wait_drained();
    set_shape(32'hffff_1234, 32'h0000_0042, 0, 0, 32'hffff_ffff, 0, 9);
    for (int t = 0; t < 6; t++) pending_times.push_back(TW'(t * 5));
    wait_drained();

    for (phase = 0; phase < 12; phase++) begin
      if (phase % 3 == 0)
        set_shape(rand_level(), rand_level(), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      else
        set_shape(rand_level(), rand_level(), $urandom_range(200),
                  $urandom_range(4) == 0 ? 0 : $urandom_range(300),
                  $urandom_range(4) == 0 ? 0 : $urandom_range(300),
                  $urandom_range(200),
                  $urandom_range(2) == 0 ? 0 : $urandom_range(1200));
      idle_pct = (phase == 5) ? 0 : 27;
      out_idle_en = (phase != 5);
      n = 75 + $urandom_range(10);
      for (int i = 0; i < n; i++) pending_times.push_back(rand_time());
      wait_drained();
    end

    $display("checked %0d voltages over directed and 12 random pulse shapes", checked_count);
    $display("covered one-shot, periodic, zero-edge and full-range settings");
    if (error_count == 0 && expected_volts.size() == 0) begin
      $display("pulse_waveform_generator_unit_tb OK");
    end else begin
      $display("pulse_waveform_generator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pwg_pkg.sv
rtl/pwg_in_if.sv
rtl/pwg_out_if.sv
rtl/pulse_waveform_generator_unit.sv
dv/pulse_waveform_generator_unit_tb.sv
